>>> rtl/cpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types and constants for the command packet parser: transaction
// payloads, configuration register map and byte role codes.
// ----------------------------------------------------------------------------
package cpp_pkg;

  // Configuration register indexes (byte address is 4 * index).
  localparam logic [1:0] RegStartCode   = 2'd0;
  localparam logic [1:0] RegWideCmdLow  = 2'd1;
  localparam logic [1:0] RegWideCmdHigh = 2'd2;

  // Register reset values.
  localparam logic [7:0] StartCodeRst   = 8'hE0;
  localparam logic [7:0] WideCmdLowRst  = 8'h40;
  localparam logic [7:0] WideCmdHighRst = 8'h4F;

  // Byte role codes carried in each result transaction.
  localparam logic [2:0] RoleIgnored = 3'd0;
  localparam logic [2:0] RoleStart   = 3'd1;
  localparam logic [2:0] RoleCmd     = 3'd2;
  localparam logic [2:0] RoleCount   = 3'd3;
  localparam logic [2:0] RoleLenHi   = 3'd4;
  localparam logic [2:0] RoleLenLo   = 3'd5;
  localparam logic [2:0] RoleData    = 3'd6;

  // Input transaction: one received byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_first;
  } cpp_in_t;

  // Result transaction: the byte tagged with its place in the frame.
  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  byte_value;
    logic [7:0]  command_code;
    logic [7:0]  param_index;
    logic [15:0] data_index;
    logic        wide_length;
    logic        frame_error;
    logic        frame_done;
  } cpp_out_t;

  // Current configuration, passed from the register file to the parser.
  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] wide_cmd_low;
    logic [7:0] wide_cmd_high;
  } cpp_cfg_t;

endpackage

>>> rtl/cpp_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_regs
// APB-style configuration register file: start code and the inclusive
// command range that uses sixteen-bit parameter lengths.
// ----------------------------------------------------------------------------
module cpp_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cpp_pkg::cpp_cfg_t cfg_o
);
  import cpp_pkg::*;

  logic [7:0] start_code_q;
  logic [7:0] wide_low_q;
  logic [7:0] wide_high_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; addresses past the map are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= StartCodeRst;
      wide_low_q   <= WideCmdLowRst;
      wide_high_q  <= WideCmdHighRst;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegStartCode:   start_code_q <= pwdata[7:0];
        RegWideCmdLow:  wide_low_q   <= pwdata[7:0];
        RegWideCmdHigh: wide_high_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (paddr[3:2])
      RegStartCode:   prdata = {24'd0, start_code_q};
      RegWideCmdLow:  prdata = {24'd0, wide_low_q};
      RegWideCmdHigh: prdata = {24'd0, wide_high_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{start_code: start_code_q, wide_cmd_low: wide_low_q,
                   wide_cmd_high: wide_high_q};

endmodule

>>> rtl/cpp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_core
// Frame parsing state and the single-pass per-byte update. When step_i is
// high the registered byte is classified and the parse state advances.
// ----------------------------------------------------------------------------
module cpp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  cpp_pkg::cpp_in_t   item_i,
  input  cpp_pkg::cpp_cfg_t  cfg_i,
  output cpp_pkg::cpp_out_t  result_o
);
  import cpp_pkg::*;

  // Parse phase codes.
  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhCmd    = 3'd1;
  localparam logic [2:0] PhCount  = 3'd2;
  localparam logic [2:0] PhLenHi  = 3'd3;
  localparam logic [2:0] PhLenLo  = 3'd4;
  localparam logic [2:0] PhData   = 3'd5;
  localparam logic [2:0] PhIgnore = 3'd6;

  logic [2:0]  phase_q,      phase_d;
  logic [7:0]  cmd_q,        cmd_d;
  logic [7:0]  params_left_q, params_left_d;
  logic [7:0]  param_cnt_q,  param_cnt_d;
  logic [15:0] len_left_q,   len_left_d;
  logic [15:0] data_cnt_q,   data_cnt_d;
  logic [7:0]  len_hi_q,     len_hi_d;

  logic        wide_cur;
  logic        wide_new;
  logic [7:0]  params_dec;
  logic [15:0] len_new;
  logic [15:0] len_dec;
  logic [2:0]  next_param_phase;
  logic [2:0]  role;
  logic [7:0]  pidx;
  logic [15:0] didx;
  logic        err;
  logic        done;
  logic        framed;
  logic [7:0]  b;

  assign b                = item_i.rx_byte;
  assign wide_cur         = (cmd_q >= cfg_i.wide_cmd_low) && (cmd_q <= cfg_i.wide_cmd_high);
  assign wide_new         = (cmd_d >= cfg_i.wide_cmd_low) && (cmd_d <= cfg_i.wide_cmd_high);
  assign params_dec       = params_left_q - 8'd1;
  assign len_new          = wide_cur ? {len_hi_q, b} : {8'd0, b};
  assign len_dec          = len_left_q - 16'd1;
  assign next_param_phase = wide_cur ? PhLenHi : PhLenLo;

  // Next state and result tags for the byte in the input register.
  always_comb begin
    phase_d       = phase_q;
    cmd_d         = cmd_q;
    params_left_d = params_left_q;
    param_cnt_d   = param_cnt_q;
    len_left_d    = len_left_q;
    data_cnt_d    = data_cnt_q;
    len_hi_d      = len_hi_q;
    role          = RoleIgnored;
    pidx          = 8'd0;
    didx          = 16'd0;
    err           = 1'b0;
    done          = 1'b0;

    if (item_i.frame_first) begin
      // A frame start always restarts parsing.
      cmd_d         = 8'd0;
      params_left_d = 8'd0;
      param_cnt_d   = 8'd0;
      len_left_d    = 16'd0;
      data_cnt_d    = 16'd0;
      len_hi_d      = 8'd0;
      if (b == cfg_i.start_code) begin
        role    = RoleStart;
        phase_d = PhCmd;
      end else begin
        err     = 1'b1;
        phase_d = PhIgnore;
      end
    end else begin
      unique case (phase_q)
        PhCmd: begin
          role    = RoleCmd;
          cmd_d   = b;
          phase_d = PhCount;
        end
        PhCount: begin
          role          = RoleCount;
          params_left_d = b;
          param_cnt_d   = 8'd0;
          if (b == 8'd0) begin
            done    = 1'b1;
            phase_d = PhIdle;
          end else begin
            phase_d = next_param_phase;
          end
        end
        PhLenHi: begin
          role     = RoleLenHi;
          pidx     = param_cnt_q;
          len_hi_d = b;
          phase_d  = PhLenLo;
        end
        PhLenLo: begin
          role       = RoleLenLo;
          pidx       = param_cnt_q;
          len_left_d = len_new;
          data_cnt_d = 16'd0;
          if (len_new == 16'd0) begin
            // Empty parameter closes at once.
            params_left_d = params_dec;
            param_cnt_d   = param_cnt_q + 8'd1;
            done          = (params_dec == 8'd0);
            phase_d       = (params_dec == 8'd0) ? PhIdle : next_param_phase;
          end else begin
            phase_d = PhData;
          end
        end
        PhData: begin
          role       = RoleData;
          pidx       = param_cnt_q;
          didx       = data_cnt_q;
          data_cnt_d = data_cnt_q + 16'd1;
          len_left_d = len_dec;
          if (len_dec == 16'd0) begin
            params_left_d = params_dec;
            param_cnt_d   = param_cnt_q + 8'd1;
            done          = (params_dec == 8'd0);
            phase_d       = (params_dec == 8'd0) ? PhIdle : next_param_phase;
          end
        end
        default: ; // idle or dropping the rest of a bad frame
      endcase
    end
  end

  assign framed = (role >= RoleCmd);

  assign result_o = '{
    byte_role:    role,
    byte_value:   b,
    command_code: framed ? cmd_d : 8'd0,
    param_index:  pidx,
    data_index:   didx,
    wide_length:  framed && wide_new,
    frame_error:  err,
    frame_done:   done
  };

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      cmd_q         <= 8'd0;
      params_left_q <= 8'd0;
      param_cnt_q   <= 8'd0;
      len_left_q    <= 16'd0;
      data_cnt_q    <= 16'd0;
      len_hi_q      <= 8'd0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      cmd_q         <= cmd_d;
      params_left_q <= params_left_d;
      param_cnt_q   <= param_cnt_d;
      len_left_q    <= len_left_d;
      data_cnt_q    <= data_cnt_d;
      len_hi_q      <= len_hi_d;
    end
  end

endmodule

>>> rtl/command_packet_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_packet_parser
// Tags each byte of a host command frame with its role, parameter index
// and data index, using a configurable start code and wide-length range.
// ----------------------------------------------------------------------------
// Pipeline: an accepted byte waits in the input register, and its result
// is offered from the result register once that register is free.
// Throughput: one byte per cycle unless the result stalls; the per-byte
// parse state update is a single combinational pass between the two registers.
// Reset: rst_ni clears the pipeline and the parse state to idle, and
// loads the registers with start code 0xE0 and wide range 0x40..0x4F.
// ----------------------------------------------------------------------------
module command_packet_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cpp_pkg::cpp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cpp_pkg::cpp_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import cpp_pkg::*;

  cpp_cfg_t cfg;
  cpp_in_t  in_q;
  cpp_out_t res;
  cpp_out_t out_q;
  logic     in_valid_q;
  logic     out_valid_q;
  logic     advance;

  cpp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move the registered byte into the result register when it is free.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  cpp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A full pipeline with a stalled result must hold off new transactions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while pipeline is full and stalled");

  // A new result only appears after a byte sat in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result produced without a registered byte");

  // Only a count, length low or data byte can complete a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_done) |->
      (out_data_o.byte_role == RoleCount || out_data_o.byte_role == RoleLenLo ||
       out_data_o.byte_role == RoleData))
    else $error("frame completed on a byte of the wrong role");

  // An error is only flagged on an ignored byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_error) |->
      (out_data_o.byte_role == RoleIgnored && !out_data_o.frame_done))
    else $error("frame error flagged on a parsed byte");

endmodule
